// ----- rtl/rid_pkg.sv -----
// shared types and codes for the interleaved rans decoder
package rid_pkg;

  // item kinds
  localparam logic [2:0] KIND_FREQ   = 3'd0;
  localparam logic [2:0] KIND_SLOT   = 3'd1;
  localparam logic [2:0] KIND_STATE  = 3'd2;
  localparam logic [2:0] KIND_CHUNK  = 3'd3;
  localparam logic [2:0] KIND_DECODE = 3'd4;

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CORRUPT = 1'b1;

  localparam int LANES = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  context_req;
    logic [7:0]  symbol_index;
    logic [12:0] frequency;
    logic [11:0] cumulative;
    logic [11:0] slot_index;
    logic [1:0]  lane_select;
    logic [31:0] initial_state;
    logic [15:0] chunk;
    logic        padding;
  } rid_item_t;

  typedef struct packed {
    logic [7:0] decoded_symbol;
    logic [1:0] lane_used;
    logic       status;
  } rid_result_t;

endpackage

// ----- rtl/rid_ram.sv -----
// generic single-write, single-read ram with registered read data
module rid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rans_interleaved_decoder.sv -----
// top level of the four-lane interleaved context-modelled rans decoder
// load items are taken while idle; a decode item steps through slot read,
// freq/cum read, multiply, add, refill check with a chunk read per refill chunk,
// and result, following the reads through the slot, freq/cum and chunk rams.
// one item is in work at a time; a result waits in the output register.
// synchronous reset clears lane states, chunk counts, lane pointer and corrupt
// flag; table and chunk rams are not cleared and must be written before use.
module rans_interleaved_decoder #(
  parameter int CONTEXTS        = 4,
  parameter int T_BITS          = 12,
  parameter int LOWER_BITS      = 16,
  parameter int CHUNK_BITS      = 16,
  parameter int CHUNKS_PER_LANE = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  rid_pkg::rid_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output rid_pkg::rid_result_t result
);
  import rid_pkg::*;

  localparam int CTXW       = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int FC_AW      = CTXW + 8;
  localparam int SLOT_AW    = CTXW + T_BITS;
  localparam int PW         = $clog2(CHUNKS_PER_LANE);
  localparam int CHK_AW     = 2 + PW;
  localparam int CW         = $clog2(CHUNKS_PER_LANE + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SYM  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_REN  = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]        state;
  logic [31:0]       lane_state [LANES];
  logic [CW-1:0]     chunks_loaded [LANES];
  logic [CW-1:0]     chunks_consumed [LANES];
  logic [1:0]        lane_pointer;
  logic              corrupt_flag;

  logic [31:0]       x;
  logic [31:0]       prod;
  logic [11:0]       cum;
  logic [CW-1:0]     pos;
  logic [7:0]        sym;
  logic [T_BITS-1:0] slot;
  logic [CTXW-1:0]   dctx;
  logic [1:0]        lane;
  logic [7:0]        res_sym;
  logic              res_status;

  logic              accept;
  logic              ctx_ok;
  logic [CTXW-1:0]   ctx_w;
  logic [CTXW-1:0]   dctx_in;
  logic              out_free;

  logic              fc_we;
  logic [FC_AW-1:0]  fc_waddr;
  logic [24:0]       fc_wdata;
  logic [FC_AW-1:0]  fc_raddr;
  logic [24:0]       fc_rdata;

  logic              slot_we;
  logic [SLOT_AW-1:0] slot_waddr;
  logic [SLOT_AW-1:0] slot_raddr;
  logic [7:0]        slot_rdata;

  logic              chk_we;
  logic [CHK_AW-1:0] chk_waddr;
  logic [CHK_AW-1:0] chk_raddr;
  logic [CHUNK_BITS-1:0] chk_rdata;

  // handshake and context decode
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign ctx_ok     = (32'(item.context_req) < CONTEXTS);
  assign ctx_w      = CTXW'(item.context_req);
  assign dctx_in    = (item.padding || !ctx_ok) ? '0 : ctx_w;

  // freq/cum table port
  assign fc_we    = accept && (item.kind == KIND_FREQ) && ctx_ok;
  assign fc_waddr = {ctx_w, item.symbol_index};
  assign fc_wdata = {item.frequency, item.cumulative};
  assign fc_raddr = {dctx, slot_rdata};

  rid_ram #(.WIDTH(25), .DEPTH(1 << FC_AW)) u_fc_ram (
    .clk   (clk),
    .we    (fc_we),
    .waddr (fc_waddr),
    .wdata (fc_wdata),
    .raddr (fc_raddr),
    .rdata (fc_rdata)
  );

  // slot-to-symbol table port
  assign slot_we    = accept && (item.kind == KIND_SLOT) && ctx_ok;
  assign slot_waddr = {ctx_w, item.slot_index[T_BITS-1:0]};
  assign slot_raddr = {dctx_in, lane_state[lane_pointer][T_BITS-1:0]};

  rid_ram #(.WIDTH(8), .DEPTH(1 << SLOT_AW)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (item.symbol_index),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // per-lane chunk store port
  assign chk_we    = accept && (item.kind == KIND_CHUNK) &&
                     (chunks_loaded[item.lane_select] < CW'(CHUNKS_PER_LANE));
  assign chk_waddr = {item.lane_select, chunks_loaded[item.lane_select][PW-1:0]};
  assign chk_raddr = {lane, pos[PW-1:0]};

  rid_ram #(.WIDTH(CHUNK_BITS), .DEPTH(LANES << PW)) u_chunk_ram (
    .clk   (clk),
    .we    (chk_we),
    .waddr (chk_waddr),
    .wdata (item.chunk[CHUNK_BITS-1:0]),
    .raddr (chk_raddr),
    .rdata (chk_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lane_pointer <= '0;
      corrupt_flag <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        lane_state[i]      <= '0;
        chunks_loaded[i]   <= '0;
        chunks_consumed[i] <= '0;
      end
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.kind == KIND_STATE) begin
              lane_state[item.lane_select] <= item.initial_state;
            end
            if (chk_we) begin
              chunks_loaded[item.lane_select] <= chunks_loaded[item.lane_select] + 1'b1;
            end
            if (item.kind == KIND_DECODE) begin
              lane_pointer <= lane_pointer + 1'b1;
              state        <= corrupt_flag ? S_EMIT : S_SYM;
            end
          end
        end
        S_SYM:  state <= S_MUL;
        S_MUL:  state <= S_ADD;
        S_ADD:  state <= S_REN;
        S_REN: begin
          if (x[31:LOWER_BITS] == '0) begin
            if (pos >= chunks_loaded[lane]) begin
              corrupt_flag <= 1'b1;
              state        <= S_EMIT;
            end else begin
              state <= S_CHK;
            end
          end else begin
            lane_state[lane]      <= x;
            chunks_consumed[lane] <= pos;
            state                 <= S_EMIT;
          end
        end
        S_CHK:  state <= S_REN;
        S_EMIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        lane       <= lane_pointer;
        dctx       <= dctx_in;
        x          <= lane_state[lane_pointer];
        slot       <= lane_state[lane_pointer][T_BITS-1:0];
        pos        <= chunks_consumed[lane_pointer];
        res_sym    <= '0;
        res_status <= STATUS_CORRUPT;
      end
      S_SYM: begin
        sym <= slot_rdata;
      end
      S_MUL: begin
        prod <= (x >> T_BITS) * {19'b0, fc_rdata[24:12]};
        cum  <= fc_rdata[11:0];
      end
      S_ADD: begin
        x <= prod + 32'(slot) - {20'b0, cum};
      end
      S_REN: begin
        if (x[31:LOWER_BITS] != '0) begin
          res_sym    <= sym;
          res_status <= STATUS_OK;
        end
      end
      S_CHK: begin
        x   <= (x << CHUNK_BITS) | 32'(chk_rdata);
        pos <= pos + 1'b1;
      end
      S_EMIT: begin
        if (out_free) begin
          result.decoded_symbol <= res_sym;
          result.lane_used      <= lane;
          result.status         <= res_status;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- sim/rid_checker.sv -----
// checker for the interleaved rans decoder: predicts each decode result and compares
module rid_checker
  import rid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  rid_item_t   item,
  input  logic        result_valid,
  input  logic        result_stall,
  input  rid_result_t result,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_BITS   = 12;
  localparam int CHUNK_DEPTH = 1024;

  // shadow copy of the decoder tables and lane state
  logic [12:0] freq_mem [4][256];
  logic [11:0] cum_mem [4][256];
  logic [7:0]  symbol_of_slot [4][4096];
  logic [15:0] chunk_mem [4][CHUNK_DEPTH];
  logic [31:0] lane_word [4];
  int          chunks_in [4];
  int          chunks_out [4];
  logic [1:0]  next_lane;
  logic        corrupt;

  rid_result_t expected_symbols [$];

  assign pending = expected_symbols.size();

  // work out the symbol a decode transfer returns and update the lane
  task automatic decode_symbol(input rid_item_t it);
    rid_result_t r;
    logic [1:0]  lane;
    logic [1:0]  dctx;
    logic [31:0] x;
    logic [11:0] slot;
    logic [7:0]  sym;
    int          pos;
    lane = next_lane;
    dctx = it.padding ? 2'd0 : it.context_req;
    next_lane = next_lane + 2'd1;
    sym = '0;
    if (!corrupt) begin
      x = lane_word[lane];
      slot = x[SLOT_BITS-1:0];
      sym = symbol_of_slot[dctx][slot];
      x = (x >> SLOT_BITS) * {19'b0, freq_mem[dctx][sym]} + {20'b0, slot}
          - {20'b0, cum_mem[dctx][sym]};
      pos = chunks_out[lane];
      // refill from the lane's unread chunks while below the lower bound
      while (x < 32'h0001_0000) begin
        if (pos >= chunks_in[lane]) begin
          corrupt = 1'b1;
          break;
        end
        x = {x[15:0], chunk_mem[lane][pos]};
        pos++;
      end
      if (!corrupt) begin
        lane_word[lane] = x;
        chunks_out[lane] = pos;
      end
    end
    r.decoded_symbol = corrupt ? 8'd0 : sym;
    r.lane_used = lane;
    r.status = corrupt ? STATUS_CORRUPT : STATUS_OK;
    expected_symbols.push_back(r);
  endtask

  always @(posedge clk) begin
    rid_result_t exp_r;
    if (rst) begin
      for (int l = 0; l < LANES; l++) begin
        lane_word[l] = '0;
        chunks_in[l] = 0;
        chunks_out[l] = 0;
      end
      next_lane = '0;
      corrupt = 1'b0;
      expected_symbols.delete();
      fails = 0;
    end else begin
      // apply an accepted input transfer
      if (item_valid && !item_stall) begin
        case (item.kind)
          KIND_FREQ: begin
            freq_mem[item.context_req][item.symbol_index] = item.frequency;
            cum_mem[item.context_req][item.symbol_index] = item.cumulative;
          end
          KIND_SLOT: begin
            symbol_of_slot[item.context_req][item.slot_index] = item.symbol_index;
          end
          KIND_STATE: begin
            lane_word[item.lane_select] = item.initial_state;
          end
          KIND_CHUNK: begin
            if (chunks_in[item.lane_select] < CHUNK_DEPTH) begin
              chunk_mem[item.lane_select][chunks_in[item.lane_select]] = item.chunk;
              chunks_in[item.lane_select]++;
            end
          end
          KIND_DECODE: begin
            decode_symbol(item);
          end
          default: ;
        endcase
      end
      // compare an accepted result transfer with the oldest prediction
      if (result_valid && !result_stall) begin
        if (expected_symbols.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: sym %0d lane %0d status %0d",
                     result.decoded_symbol, result.lane_used, result.status);
        end else begin
          exp_r = expected_symbols.pop_front();
          if (result !== exp_r) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp sym %0d lane %0d st %0d, got sym %0d lane %0d st %0d",
                       exp_r.decoded_symbol, exp_r.lane_used, exp_r.status,
                       result.decoded_symbol, result.lane_used, result.status);
          end
        end
      end
    end
  end

endmodule

// ----- sim/tb.sv -----
// testbench top for the interleaved rans decoder: stimulus, idling and verdict
module tb;
  import rid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_W = $bits(rid_item_t);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  rid_item_t   item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  rid_result_t result;
  int          fails;
  int          pending;

  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_cnt = 0;
  logic        seen_corrupt = 1'b0;
  int          quiet_cycles = 0;

  rans_interleaved_decoder DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  rid_checker u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .fails(fails), .pending(pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      result_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1)
        hold_done <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
    if (result_valid && !result_stall && result.status == STATUS_CORRUPT)
      seen_corrupt <= 1'b1;
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // offer one transfer, with random sender gaps, and wait for acceptance
  task automatic send(input rid_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall)
      @(posedge clk);
  endtask

  function automatic rid_item_t noise_item(input logic [2:0] kind);
    rid_item_t it;
    it = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
    it.kind = kind;
    return it;
  endfunction

  task automatic send_freq(input logic [1:0] ctx, input logic [7:0] sym,
                           input logic [12:0] f, input logic [11:0] c);
    rid_item_t it;
    it = noise_item(KIND_FREQ);
    it.context_req = ctx;
    it.symbol_index = sym;
    it.frequency = f;
    it.cumulative = c;
    send(it);
  endtask

  task automatic send_chunk(input logic [1:0] lane, input logic [15:0] value);
    rid_item_t it;
    it = noise_item(KIND_CHUNK);
    it.lane_select = lane;
    it.chunk = value;
    send(it);
  endtask

  task automatic send_state(input logic [1:0] lane, input logic [31:0] value);
    rid_item_t it;
    it = noise_item(KIND_STATE);
    it.lane_select = lane;
    it.initial_state = value;
    send(it);
  endtask

  task automatic send_decode(input logic [1:0] ctx, input logic pad);
    rid_item_t it;
    it = noise_item(KIND_DECODE);
    it.context_req = ctx;
    it.padding = pad;
    send(it);
  endtask

  function automatic logic [12:0] pick_freq();
    if ($urandom_range(0, 2) == 0)
      return 13'($urandom_range(0, 15));
    return 13'($urandom_range(0, 4096));
  endfunction

  initial begin
    rid_item_t it;
    int        r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // load every table entry so no decode reads an unwritten one
    for (int c = 0; c < 4; c++) begin
      for (int s = 0; s < 256; s++)
        send_freq(2'(c), 8'(s), pick_freq(), 12'($urandom));
      for (int s = 0; s < 4096; s++) begin
        it = noise_item(KIND_SLOT);
        it.context_req = 2'(c);
        it.slot_index = 12'(s);
        send(it);
      end
    end
    // chunk supply: lanes 0 to 2 partly filled, lane 3 past full
    for (int n = 0; n < 150; n++)
      for (int l = 0; l < 3; l++)
        send_chunk(2'(l), 16'($urandom));
    for (int n = 0; n < 1028; n++)
      send_chunk(2'd3, 16'($urandom));

    // directed: field extremes, every kind, padding, unused kinds
    send_freq(2'd3, 8'd255, 13'd4096, 12'd4095);
    send_freq(2'd0, 8'd0, 13'd0, 12'd0);
    it = noise_item(KIND_SLOT);
    it.context_req = 2'd3;
    it.slot_index = 12'hFFF;
    it.symbol_index = 8'd255;
    send(it);
    send_chunk(2'd0, 16'hFFFF);
    send_chunk(2'd1, 16'h0000);
    send_state(2'd0, 32'd0);
    send_state(2'd1, 32'hFFFF_FFFF);
    send_state(2'd2, 32'h0000_0FFF);
    send_state(2'd3, 32'h0001_0000);
    for (int k = 0; k < 4; k++)
      send_decode(2'(k), 1'b0);
    send_decode(2'd3, 1'b1);
    send_decode(2'd2, 1'b1);
    send(noise_item(3'd5));
    send(noise_item(3'd6));
    send(noise_item(3'd7));
    send_decode(2'd1, 1'b0);

    // random part, cycling through idling phases
    for (int i = 0; i < 1200; i++) begin
      case ((i / 100) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      if (i == 50)
        hold_go <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_decode(2'($urandom), 1'($urandom));
      end else if (r < 60) begin
        send_chunk(2'($urandom), 16'($urandom));
      end else if (r < 72) begin
        send_freq(2'($urandom), 8'($urandom), pick_freq(), 12'($urandom));
      end else if (r < 82) begin
        send(noise_item(KIND_SLOT));
      end else if (r < 90) begin
        send_state(2'($urandom), $urandom);
      end else if (r < 95) begin
        send(noise_item(3'($urandom_range(5, 7))));
      end else begin
        send_decode(2'($urandom), 1'b1);
      end
    end

    // drain the lanes: zero frequencies in context 0 force a refill per decode
    idle_pct = 13;
    stall_pct = 13;
    for (int s = 0; s < 256; s++)
      send_freq(2'd0, 8'(s), 13'd0, 12'd0);
    for (int n = 0; n < 4000 && !seen_corrupt; n++)
      send_decode(2'($urandom), 1'b1);
    // decodes after the sticky corrupt status
    for (int n = 0; n < 6; n++)
      send_decode(2'($urandom), 1'($urandom));
    item_valid <= 1'b0;

    while (pending != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- rans_interleaved_decoder.f -----
rtl/rid_pkg.sv
rtl/rid_ram.sv
rtl/rans_interleaved_decoder.sv
sim/rid_checker.sv
sim/tb.sv
